[rtl/smpt_pkg.sv]
// Shared types and codes for the sorted match position table.
package smpt_pkg;

  typedef enum logic [2:0] {
    K_CLEAR  = 3'd0,
    K_APPEND = 3'd1,
    K_READ   = 3'd2,
    K_RANGE  = 3'd3,
    K_NEXT   = 3'd4,
    K_PREV   = 3'd5,
    K_SHIFT  = 3'd6,
    K_NOP    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } st_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_TARGET,
    S_FETCH,
    S_WAIT,
    S_FIN
  } ctrl_state_t;

  localparam int unsigned EntryW = 48;

  typedef struct packed {
    logic  accept;
    logic  do_clear;
    logic  do_append;
    logic  set_status;
    st_t   status;
    logic  ptr_clr;
    logic  scan_rd;
    logic  eval;
    logic  tgt_init;
    logic  tgt_back;
    logic  res_pos;
    logic  out_load;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  empty;
    logic  full;
    logic  idx_bad;
    logic  scan_done;
    logic  on_caret;
    logic  out_free;
  } dp_sts_t;

endpackage

[rtl/sorted_match_position_table.sv]
// Top level of the sorted match position table.
// Usage:
//   One input beat on in_* carries one operation (in_kind): clear, append,
//   read, range query, find next, find previous, shift, no-op. Every operation
//   yields exactly one result beat on out_*, carrying status, window
//   indices, a position and the entry count after the operation.
//   Both channels are valid/ready; a beat moves when valid and ready are high.
// Operation sequence:
//   Clear, append, no-op, and rejected operations: decode, then finish.
//   Read: a range check, then one registered RAM read of the indexed entry.
//   Range query and shift: a scan, one entry a cycle through the read port
//   of the entry RAM, up to the last entry or the first one past the query.
//   Find next/previous: scan as above plus a refetch of the target entry,
//   done twice for previous when the first sits on the caret. One operation
//   is in flight at a time: a new beat is taken once the result is loaded.
// Reset: the entry count goes to zero; the RAM contents are not cleared.
// Stall: a finished result sits in the output register while the next beat
//   is accepted and worked on; that beat waits to finish until the held
//   result is taken.
module sorted_match_position_table #(
  parameter int unsigned DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_row,
  input  logic [15:0] in_col,
  input  logic [15:0] in_row_end,
  input  logic [15:0] in_entry_len,
  input  logic [15:0] in_old_len,
  input  logic [15:0] in_new_len,
  input  logic [7:0]  in_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_first_index,
  output logic [7:0]  out_last_index,
  output logic [15:0] out_pos_row,
  output logic [15:0] out_pos_col,
  output logic [15:0] out_pos_len,
  output logic [8:0]  out_count
);
  import smpt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: one beat at a time, drives the datapath by command strobes
  smpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: entry RAM, count, scan pointer, result and output registers
  smpt_dp #(.DEPTH(DEPTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_kind         (in_kind),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_row_end      (in_row_end),
    .in_entry_len    (in_entry_len),
    .in_old_len      (in_old_len),
    .in_new_len      (in_new_len),
    .in_index        (in_index),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_first_index (out_first_index),
    .out_last_index  (out_last_index),
    .out_pos_row     (out_pos_row),
    .out_pos_col     (out_pos_col),
    .out_pos_len     (out_pos_len),
    .out_count       (out_count)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready held after accept");
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_count == 9'(DEPTH)))
    else $error("full status with room left");
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready)) else $error("result without an operation");
`endif

endmodule

[rtl/smpt_ram.sv]
// Generic simple dual-port RAM with registered read.
module smpt_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/smpt_dp.sv]
// Datapath: operand capture, entry store, scan pointer and result registers.
module smpt_dp #(
  parameter int unsigned DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [2:0]      in_kind,
  input  logic [15:0]     in_row,
  input  logic [15:0]     in_col,
  input  logic [15:0]     in_row_end,
  input  logic [15:0]     in_entry_len,
  input  logic [15:0]     in_old_len,
  input  logic [15:0]     in_new_len,
  input  logic [7:0]      in_index,
  input  smpt_pkg::dp_cmd_t cmd,
  output smpt_pkg::dp_sts_t sts,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_status,
  output logic [7:0]      out_first_index,
  output logic [7:0]      out_last_index,
  output logic [15:0]     out_pos_row,
  output logic [15:0]     out_pos_col,
  output logic [15:0]     out_pos_len,
  output logic [8:0]      out_count
);
  import smpt_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // captured operands
  kind_t       q_kind_r;
  logic [15:0] q_row_r, q_col_r, q_row_end_r, q_len_r, q_old_r, q_new_r;
  logic [7:0]  q_index_r;

  logic [CW-1:0] count_r, ptr_r, k_r;
  logic [AW-1:0] idx_r, tgt_r;
  logic          dv_r, found_r, out_valid_r;

  st_t         res_status_r;
  logic [7:0]  res_first_r, res_last_r;
  logic [15:0] res_row_r, res_col_r, res_len_r;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;
  logic [15:0]       rd_row, rd_col, rd_len;
  logic [17:0]       col_sum;
  logic [15:0]       col_sat;
  logic              issue, brk, in_win, last_ent, hit, shift_hit;
  logic [CW-1:0]     count_m1;

  assign rd_row   = ram_rdata[47:32];
  assign rd_col   = ram_rdata[31:16];
  assign rd_len   = ram_rdata[15:0];
  assign count_m1 = count_r - CW'(1);

  assign issue    = cmd.scan_rd && (ptr_r < count_r);
  assign ram_raddr = cmd.scan_rd ? ptr_r[AW-1:0] : tgt_r;

  assign in_win   = (rd_row >= q_row_r) && (rd_row <= q_row_end_r);
  assign last_ent = (CW'(idx_r) == count_m1);
  assign hit      = cmd.eval && dv_r;

  always_comb begin
    unique case (q_kind_r)
      K_RANGE: brk = rd_row > q_row_end_r;
      K_SHIFT: brk = rd_row > q_row_r;
      default: brk = (rd_row > q_row_r) || ((rd_row == q_row_r) && (rd_col > q_col_r));
    endcase
  end

  // saturating column move, 18-bit two's complement
  assign col_sum = 18'(rd_col) + 18'(q_new_r) - 18'(q_old_r);
  always_comb begin
    priority if (col_sum[17]) col_sat = 16'd0;
    else if (col_sum[16])     col_sat = 16'hFFFF;
    else                      col_sat = col_sum[15:0];
  end

  assign shift_hit = hit && (q_kind_r == K_SHIFT) && (rd_row == q_row_r) && (rd_col > q_col_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = {rd_row, col_sat, rd_len};
    if (cmd.do_append && (count_r < CW'(DEPTH))) begin
      ram_we    = 1'b1;
      ram_waddr = count_r[AW-1:0];
      ram_wdata = {q_row_r, q_col_r, q_len_r};
    end else if (shift_hit) begin
      ram_we = 1'b1;
    end
  end

  smpt_ram #(.WIDTH(EntryW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q_kind_r    <= kind_t'(in_kind);
      q_row_r     <= in_row;
      q_col_r     <= in_col;
      q_row_end_r <= in_row_end;
      q_len_r     <= in_entry_len;
      q_old_r     <= in_old_len;
      q_new_r     <= in_new_len;
      q_index_r   <= in_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dv_r <= issue;
      if (cmd.do_clear) begin
        count_r <= '0;
      end else if (cmd.do_append && (count_r < CW'(DEPTH))) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.accept) begin
        found_r <= 1'b0;
      end else if (hit && (q_kind_r == K_RANGE) && in_win) begin
        found_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ptr_clr) begin
      ptr_r <= '0;
    end else if (issue) begin
      ptr_r <= ptr_r + CW'(1);
    end
    idx_r <= ptr_r[AW-1:0];

    if (cmd.accept) begin
      k_r <= count_r;
    end else if (hit && brk && (q_kind_r != K_RANGE)) begin
      k_r <= CW'(idx_r);
    end

    if (cmd.tgt_init) begin
      unique case (q_kind_r)
        K_NEXT:  tgt_r <= (k_r >= count_r) ? '0 : k_r[AW-1:0];
        K_PREV:  tgt_r <= (k_r == '0) ? count_m1[AW-1:0] : AW'(k_r - CW'(1));
        default: tgt_r <= AW'(q_index_r);
      endcase
    end else if (cmd.tgt_back) begin
      tgt_r <= (tgt_r == '0) ? count_m1[AW-1:0] : tgt_r - AW'(1);
    end
  end

  // result collection
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_status_r <= ST_OK;
      res_first_r  <= '0;
      res_last_r   <= '0;
      res_row_r    <= '0;
      res_col_r    <= '0;
      res_len_r    <= '0;
    end else begin
      if (cmd.set_status) begin
        res_status_r <= cmd.status;
      end
      if (hit && (q_kind_r == K_RANGE)) begin
        if (in_win) begin
          if (!found_r) res_first_r <= 8'(idx_r);
          res_last_r <= 8'(idx_r);
        end else if (sts.scan_done && !found_r) begin
          res_status_r <= ST_NONE;
        end
      end
      if (cmd.res_pos) begin
        res_row_r <= rd_row;
        res_col_r <= rd_col;
        if (q_kind_r == K_READ) res_len_r <= rd_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status      <= res_status_r;
      out_first_index <= res_first_r;
      out_last_index  <= res_last_r;
      out_pos_row     <= res_row_r;
      out_pos_col     <= res_col_r;
      out_pos_len     <= res_len_r;
      out_count       <= 9'(count_r);
    end
  end

  assign out_valid = out_valid_r;

  assign sts.kind      = q_kind_r;
  assign sts.empty     = (count_r == '0);
  assign sts.full      = (count_r >= CW'(DEPTH));
  assign sts.idx_bad   = (32'(q_index_r) >= 32'(count_r));
  assign sts.scan_done = hit && (brk || last_ent);
  assign sts.on_caret  = (rd_row == q_row_r) && (rd_col == q_col_r);
  assign sts.out_free  = !out_valid_r || out_ready;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("entry count above depth");
  a_no_dual_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.do_append && shift_hit)) else $error("append and shift write collide");
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> (CW'(idx_r) < count_r)) else $error("scan past last entry");
`endif

endmodule

[rtl/smpt_ctrl.sv]
// Operation sequencer for the match position table.
module smpt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output smpt_pkg::dp_cmd_t cmd,
  input  smpt_pkg::dp_sts_t sts
);
  import smpt_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        second_r, second_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    cmd        = '0;
    cmd.status = ST_OK;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        second_nxt = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FIN;
        unique case (sts.kind)
          K_CLEAR: cmd.do_clear = 1'b1;
          K_APPEND: begin
            if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.do_append = 1'b1;
            end
          end
          K_READ: begin
            if (sts.idx_bad) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_RANGE;
            end else begin
              state_nxt = S_TARGET;
            end
          end
          K_RANGE, K_NEXT, K_PREV, K_SHIFT: begin
            if (sts.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NONE;
            end else begin
              cmd.ptr_clr = 1'b1;
              state_nxt   = S_SCAN;
            end
          end
          K_NOP: ;
        endcase
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        cmd.eval    = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ((sts.kind == K_NEXT) || (sts.kind == K_PREV)) ? S_TARGET : S_FIN;
        end
      end
      S_TARGET: begin
        cmd.tgt_init = 1'b1;
        state_nxt    = S_FETCH;
      end
      S_FETCH: state_nxt = S_WAIT;
      S_WAIT: begin
        if ((sts.kind == K_PREV) && sts.on_caret && !second_r) begin
          cmd.tgt_back = 1'b1;
          second_nxt   = 1'b1;
          state_nxt    = S_FETCH;
        end else begin
          cmd.res_pos = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_second_only_prev: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT && second_r) |-> (sts.kind == K_PREV)) else $error("refetch outside prev");
  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (state_r == S_IDLE)) else $error("result load outside finish");
  a_scan_has_entries: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !sts.empty) else $error("scan on empty table");
`endif

endmodule

[dv/sorted_match_position_table_test.sv]
// Testbench for the sorted match position table: directed and random operations.
module sorted_match_position_table_test;
  import smpt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned STALL_LIMIT = 20000;

  // One expected result beat.
  typedef struct {
    st_t         status;
    logic [7:0]  first_index;
    logic [7:0]  last_index;
    logic [15:0] pos_row;
    logic [15:0] pos_col;
    logic [15:0] pos_len;
    logic [8:0]  count;
  } table_result_t;

  // Operation beat as driven on in_*.
  typedef struct {
    kind_t       kind;
    logic [15:0] row;
    logic [15:0] col;
    logic [15:0] row_end;
    logic [15:0] entry_len;
    logic [15:0] old_len;
    logic [15:0] new_len;
    logic [7:0]  index;
  } table_op_t;

  // Mirror of the match table plus the queue of results still owed by the block.
  class match_table_board;
    logic [15:0]   rows[TABLE_DEPTH];
    logic [15:0]   cols[TABLE_DEPTH];
    logic [15:0]   lens[TABLE_DEPTH];
    int unsigned   held;
    table_result_t owed[$];
    int unsigned   mismatches;
    int unsigned   checked;

    function new();
      held = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    // Entries at or before the caret.
    function int unsigned split_at(logic [15:0] r, logic [15:0] c);
      int unsigned i;
      for (i = 0; i < held; i++) begin
        if (rows[i] > r) break;
        if (rows[i] == r && cols[i] > c) break;
      end
      return i;
    endfunction

    function void note_op(table_op_t op);
      table_result_t res;
      int unsigned   k;
      int            v;
      bit            hit;
      res = '{ST_OK, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 9'd0};
      case (op.kind)
        K_CLEAR: held = 0;
        K_APPEND: begin
          if (held >= TABLE_DEPTH) res.status = ST_FULL;
          else begin
            rows[held] = op.row;
            cols[held] = op.col;
            lens[held] = op.entry_len;
            held++;
          end
        end
        K_READ: begin
          if (op.index >= held) res.status = ST_RANGE;
          else begin
            res.pos_row = rows[op.index];
            res.pos_col = cols[op.index];
            res.pos_len = lens[op.index];
          end
        end
        K_RANGE: begin
          hit = 0;
          for (int unsigned i = 0; i < held; i++) begin
            if (rows[i] >= op.row && rows[i] <= op.row_end) begin
              if (!hit) res.first_index = i[7:0];
              res.last_index = i[7:0];
              hit = 1;
            end
            if (rows[i] > op.row_end) break;
          end
          if (!hit) begin
            res.status = ST_NONE;
            res.first_index = 0;
            res.last_index = 0;
          end
        end
        K_NEXT: begin
          if (held == 0) res.status = ST_NONE;
          else begin
            k = split_at(op.row, op.col);
            if (k >= held) k = 0;
            res.pos_row = rows[k];
            res.pos_col = cols[k];
          end
        end
        K_PREV: begin
          if (held == 0) res.status = ST_NONE;
          else begin
            k = split_at(op.row, op.col);
            k = (k == 0) ? held - 1 : k - 1;
            // a match sitting on the caret is skipped
            if (rows[k] == op.row && cols[k] == op.col) k = (k == 0) ? held - 1 : k - 1;
            res.pos_row = rows[k];
            res.pos_col = cols[k];
          end
        end
        K_SHIFT: begin
          if (held == 0) res.status = ST_NONE;
          else begin
            for (int unsigned i = 0; i < held; i++) begin
              if (rows[i] > op.row) break;
              if (rows[i] == op.row && cols[i] > op.col) begin
                v = int'(cols[i]) + int'(op.new_len) - int'(op.old_len);
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                cols[i] = v[15:0];
              end
            end
          end
        end
        default: ;
      endcase
      res.count = held[8:0];
      owed = {owed, res};
    endfunction

    function void check_result(table_result_t got);
      table_result_t exp;
      checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result beat with nothing expected");
        return;
      end
      exp = owed.pop_front();
      if (got.status !== exp.status || got.first_index !== exp.first_index ||
          got.last_index !== exp.last_index || got.pos_row !== exp.pos_row ||
          got.pos_col !== exp.pos_col || got.pos_len !== exp.pos_len ||
          got.count !== exp.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: beat %0d exp st=%0d f=%0d l=%0d r=%0d c=%0d len=%0d n=%0d, got st=%0d f=%0d l=%0d r=%0d c=%0d len=%0d n=%0d",
                   checked, exp.status, exp.first_index, exp.last_index, exp.pos_row,
                   exp.pos_col, exp.pos_len, exp.count, got.status, got.first_index,
                   got.last_index, got.pos_row, got.pos_col, got.pos_len, got.count);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_kind;
  logic [15:0] in_row;
  logic [15:0] in_col;
  logic [15:0] in_row_end;
  logic [15:0] in_entry_len;
  logic [15:0] in_old_len;
  logic [15:0] in_new_len;
  logic [7:0]  in_index;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [7:0]  out_first_index;
  logic [7:0]  out_last_index;
  logic [15:0] out_pos_row;
  logic [15:0] out_pos_col;
  logic [15:0] out_pos_len;
  logic [8:0]  out_count;

  match_table_board board;
  int unsigned      idle_cycles;
  int unsigned      op_total;
  int unsigned      kind_seen[8];
  bit               rx_stall_on;

  // Sorted-stream generator state: next append keeps row/col ascending.
  logic [15:0] gen_row;
  logic [15:0] gen_col;

  sorted_match_position_table #(.DEPTH(TABLE_DEPTH)) dut (.*);

  initial clk = 0;
  always #4 clk = ~clk;

  // Receiver: stalls come in patterned windows; some windows have no stall at all.
  int unsigned rx_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_phase <= 0;
    end else begin
      rx_phase <= rx_phase + 1;
      if (!rx_stall_on) out_ready <= 1'b1;
      else out_ready <= (rx_phase % 7 < 4) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 1) == 1);
    end
  end
  always @(posedge clk) if (rx_phase % 300 == 0) rx_stall_on <= $urandom_range(0, 3) != 0;

  // Result monitor and idle watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        board.check_result('{st_t'(out_status), out_first_index, out_last_index,
                             out_pos_row, out_pos_col, out_pos_len, out_count});
      if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Put one operation on the input port and hold it until accepted.
  task automatic send_op(table_op_t op);
    in_valid     <= 1'b1;
    in_kind      <= op.kind;
    in_row       <= op.row;
    in_col       <= op.col;
    in_row_end   <= op.row_end;
    in_entry_len <= op.entry_len;
    in_old_len   <= op.old_len;
    in_new_len   <= op.new_len;
    in_index     <= op.index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_op(op);
    kind_seen[op.kind]++;
    op_total++;
  endtask

  task automatic idle_gap(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic table_op_t make_op(kind_t k, logic [15:0] r, logic [15:0] c);
    table_op_t op;
    op.kind = k;
    op.row = r;
    op.col = c;
    op.row_end = 16'($urandom);
    op.entry_len = 16'($urandom);
    op.old_len = 16'($urandom);
    op.new_len = 16'($urandom);
    op.index = 8'($urandom);
    return op;
  endfunction

  // Next append in ascending order; small steps so rows repeat.
  function automatic table_op_t sorted_append();
    if ($urandom_range(0, 2) == 0) begin
      gen_row = gen_row + 16'($urandom_range(1, 3));
      gen_col = 16'($urandom_range(0, 40));
    end else gen_col = gen_col + 16'($urandom_range(0, 30));
    return make_op(K_APPEND, gen_row, gen_col);
  endfunction

  // Random operation aimed near stored contents.
  function automatic table_op_t random_op();
    table_op_t   op;
    int unsigned pick;
    int unsigned n;
    n = board.held;
    pick = $urandom_range(0, 99);
    if (pick < 30) op = sorted_append();
    else if (pick < 40) op = make_op(K_READ, 16'($urandom), 16'($urandom));
    else if (pick < 55) op = make_op(K_RANGE, 16'($urandom), 16'($urandom));
    else if (pick < 68) op = make_op(K_NEXT, 16'($urandom), 16'($urandom));
    else if (pick < 81) op = make_op(K_PREV, 16'($urandom), 16'($urandom));
    else if (pick < 92) op = make_op(K_SHIFT, 16'($urandom), 16'($urandom));
    else if (pick < 95) op = make_op(K_CLEAR, 16'($urandom), 16'($urandom));
    else if (pick < 97) op = make_op(K_NOP, 16'($urandom), 16'($urandom));
    else op = make_op(kind_t'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
    if (op.kind == K_CLEAR) begin
      gen_row = 16'($urandom_range(0, 65000));
      gen_col = 0;
    end
    // aim most queries at stored positions so matches and caret hits happen
    if (n > 0 && op.kind != K_APPEND && $urandom_range(0, 3) != 0) begin
      int unsigned j;
      j = $urandom_range(0, n - 1);
      op.row = board.rows[j];
      op.col = $urandom_range(0, 1) ? board.cols[j] : board.cols[j] + 16'($urandom_range(0, 3)) - 16'd1;
      op.row_end = op.row + 16'($urandom_range(0, 4));
      if (op.kind == K_READ) op.index = 8'($urandom_range(0, n));
      if (op.kind == K_SHIFT && $urandom_range(0, 1)) op.old_len = 16'($urandom_range(0, 20));
    end
    return op;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
  endtask

  initial begin
    table_op_t op;
    int unsigned burst;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = K_NOP;
    in_row = '0;
    in_col = '0;
    in_row_end = '0;
    in_entry_len = '0;
    in_old_len = '0;
    in_new_len = '0;
    in_index = '0;
    rx_stall_on = 1'b0;
    idle_cycles = 0;
    op_total = 0;
    gen_row = 0;
    gen_col = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-table cases first.
    send_op(make_op(K_NEXT, 16'd5, 16'd5));
    send_op(make_op(K_PREV, 16'd5, 16'd5));
    op = make_op(K_SHIFT, 16'd0, 16'd0);
    send_op(op);
    op = make_op(K_RANGE, 16'd0, 16'd0);
    op.row_end = 16'hFFFF;
    send_op(op);
    op = make_op(K_READ, 16'd0, 16'd0);
    op.index = 8'd0;
    send_op(op);
    send_op(make_op(K_NOP, 16'hFFFF, 16'hFFFF));
    // Extremes, caret hits, wrap, saturation both ways.
    op = make_op(K_APPEND, 16'd0, 16'd0);
    op.entry_len = 16'd0;
    send_op(op);
    op = make_op(K_APPEND, 16'd7, 16'd10);
    op.entry_len = 16'hFFFF;
    send_op(op);
    send_op(make_op(K_APPEND, 16'd7, 16'd20));
    send_op(make_op(K_APPEND, 16'hFFFF, 16'hFFFF));
    send_op(make_op(K_NEXT, 16'hFFFF, 16'hFFFF));
    send_op(make_op(K_PREV, 16'd0, 16'd0));
    send_op(make_op(K_PREV, 16'd7, 16'd20));
    send_op(make_op(K_NEXT, 16'd7, 16'd10));
    op = make_op(K_RANGE, 16'd7, 16'd0);
    op.row_end = 16'd7;
    send_op(op);
    op = make_op(K_RANGE, 16'd8, 16'd0);
    op.row_end = 16'd9;
    send_op(op);
    op = make_op(K_SHIFT, 16'd7, 16'd10);
    op.old_len = 16'hFFFF;
    op.new_len = 16'd0;
    send_op(op);
    op = make_op(K_SHIFT, 16'd7, 16'd0);
    op.old_len = 16'd0;
    op.new_len = 16'hFFFF;
    send_op(op);
    for (int i = 0; i < 4; i++) begin
      op = make_op(K_READ, 16'd0, 16'd0);
      op.index = (i == 3) ? 8'hFF : 8'(i);
      send_op(op);
    end
    send_op(make_op(K_CLEAR, 16'd0, 16'd0));
    drain();

    // Fill the table to overflow, then exercise full-table scans.
    for (int i = 0; i < TABLE_DEPTH + 2; i++) send_op(sorted_append());
    for (int i = 0; i < 8; i++) send_op(random_op());
    op = make_op(K_READ, 16'd0, 16'd0);
    op.index = 8'hFF;
    send_op(op);
    send_op(make_op(K_CLEAR, 16'd0, 16'd0));

    // Random bursts with gaps.
    while (op_total < 1400) begin
      burst = $urandom_range(1, 30);
      repeat (burst) send_op(random_op());
      if ($urandom_range(0, 9) == 0) drain();
      else if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    drain();
    repeat (DEPTH_TAIL()) @(posedge clk);
    $display("Covered %0d operations: clear %0d, append %0d, read %0d, range %0d,",
             op_total, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    $display("  next %0d, prev %0d, shift %0d, no-op %0d; %0d results checked",
             kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7], board.checked);
    if (board.mismatches == 0 && board.owed.size() == 0) $display("Test completed successfully");
    else begin
      $display("%0d mismatches", board.mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

  // Cycles to wait after the last result: a full scan plus refetch.
  function automatic int unsigned DEPTH_TAIL();
    return TABLE_DEPTH + 20;
  endfunction

endmodule
